@@ src/assert_macros.svh @@
// Assertion macros shared by the filter allocator modules.
// No dependencies; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// When cond holds, prop must hold at the next clock edge.
`define ASSERT_NEXT(lbl, clk, rst, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

@@ src/cafa_pkg.sv @@
// Types and constants of the CAN acceptance filter allocator.
// No dependencies; imported by the controller, datapath and top level.
package cafa_pkg;

  localparam int FILTER_SLOTS_DEF = 14;
  localparam int SLOT_W           = 4;

  typedef enum logic [1:0] {
    ST_ADDED  = 2'd0,
    ST_NONE   = 2'd1,
    ST_REPEAT = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN
  } ctrl_state_t;

  // One filter request; the table stores entries in the same layout.
  typedef struct packed {
    logic       match_dest;
    logic       match_src;
    logic [5:0] dest_type;
    logic [3:0] dest_id;
    logic [5:0] source_type;
    logic [3:0] src_id;
  } req_t;

  typedef struct packed {
    status_t           status;
    logic [SLOT_W-1:0] slot;
    logic [15:0]       id_high;
    logic [15:0]       id_low;
    logic [15:0]       mask_high;
    logic [15:0]       mask_low;
  } res_t;

  // Controller -> datapath commands.
  typedef struct packed {
    logic    load;
    logic    step;
    logic    write_entry;
    logic    emit;
    status_t status;
  } dp_cmd_t;

  // Datapath -> controller status.
  typedef struct packed {
    logic no_match;
    logic repeat_hit;
    logic last;
    logic free_found;
  } dp_stat_t;

endpackage

@@ src/cafa_ctrl.sv @@
// Controller FSM of the filter allocator: sequences the table scan.
// Depends on cafa_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cafa_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  cafa_pkg::dp_stat_t stat,
  output cafa_pkg::dp_cmd_t  cmd
);
  import cafa_pkg::*;

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.status = ST_ADDED;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          if (stat.no_match) begin
            // refused at once, fields all zero
            cmd.emit   = 1'b1;
            cmd.status = ST_NONE;
          end else begin
            cmd.load   = 1'b1;
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (stat.repeat_hit) begin
          cmd.emit   = 1'b1;
          cmd.status = ST_REPEAT;
          state_next = S_IDLE;
        end else if (stat.last) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
          if (stat.free_found) begin
            cmd.write_entry = 1'b1;
            cmd.status      = ST_ADDED;
          end else begin
            cmd.status = ST_FULL;
          end
        end else begin
          cmd.step = 1'b1;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);

  `ASSERT_ALWAYS(a_write_only_on_add, clk, rst,
    !cmd.write_entry || (cmd.emit && cmd.status == ST_ADDED), "write without add result")
  `ASSERT_ALWAYS(a_load_only_idle, clk, rst,
    !cmd.load || (state == S_IDLE && start), "load outside accepted start")
  `ASSERT_NEXT(a_emit_frees, clk, rst, cmd.emit, !busy, "still busy after result")

endmodule

@@ src/cafa_dp.sv @@
// Datapath of the filter allocator: request latch, filter table, scan
// index, bus format register and result register. Depends on cafa_pkg.
`include "assert_macros.svh"

module cafa_dp #(
  parameter int FILTER_SLOTS = cafa_pkg::FILTER_SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  cafa_pkg::req_t     request,
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data,
  input  cafa_pkg::dp_cmd_t  cmd,
  output cafa_pkg::dp_stat_t stat,
  output logic               done,
  output cafa_pkg::res_t     result
);
  import cafa_pkg::*;

  localparam int IDX_W = (FILTER_SLOTS > 1) ? $clog2(FILTER_SLOTS) : 1;

  localparam logic [15:0] MKH_BASE  = 16'hE000;
  localparam logic [15:0] MKL_BASE  = 16'h0006;
  localparam logic [15:0] MKH_D_F0  = 16'hFFE0;
  localparam logic [15:0] MKH_S_F0  = 16'h001F;
  localparam logic [15:0] MKL_S_F0  = 16'hE000;
  localparam logic [15:0] MKH_D_F1  = 16'hFFF0;
  localparam logic [15:0] MKH_S_F1  = 16'h000F;
  localparam logic [15:0] MKL_S_F1  = 16'hF800;

  req_t             req_q;
  req_t             tbl [FILTER_SLOTS];
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] free_idx;
  logic             free_vld;
  logic             bus_format;

  req_t             cur;
  logic             cur_free;
  logic             same;
  logic [IDX_W-1:0] wr_idx;
  res_t             res_next;

  assign cur      = tbl[idx];
  assign cur_free = !cur.match_dest && !cur.match_src;

  // Only entries with identical flags are candidates; unmatched fields ignored.
  always_comb begin
    same = (cur.match_dest == req_q.match_dest) && (cur.match_src == req_q.match_src);
    if (req_q.match_dest &&
        (cur.dest_type != req_q.dest_type || cur.dest_id != req_q.dest_id)) begin
      same = 1'b0;
    end
    if (req_q.match_src &&
        (cur.source_type != req_q.source_type || cur.src_id != req_q.src_id)) begin
      same = 1'b0;
    end
  end

  assign wr_idx = free_vld ? free_idx : idx;

  assign stat.no_match   = !request.match_dest && !request.match_src;
  assign stat.repeat_hit = same;
  assign stat.last       = (idx == IDX_W'(FILTER_SLOTS - 1));
  assign stat.free_found = free_vld || cur_free;

  always_comb begin
    res_next = '0;
    res_next.status = cmd.status;
    if (cmd.status == ST_ADDED) begin
      res_next.slot      = SLOT_W'(wr_idx);
      res_next.mask_high = MKH_BASE;
      res_next.mask_low  = MKL_BASE;
      if (!bus_format) begin
        res_next.id_high = {3'b101, req_q.dest_type[3:0], req_q.dest_id,
                            req_q.source_type[3:0], req_q.src_id[3]};
        res_next.id_low  = {req_q.src_id[2:0], 13'h0004};
        if (req_q.match_dest) res_next.mask_high = res_next.mask_high | MKH_D_F0;
        if (req_q.match_src) begin
          res_next.mask_high = res_next.mask_high | MKH_S_F0;
          res_next.mask_low  = res_next.mask_low | MKL_S_F0;
        end
      end else begin
        res_next.id_high = {3'b001, req_q.dest_type, req_q.dest_id[2:0],
                            req_q.source_type[5:2]};
        res_next.id_low  = {req_q.source_type[1:0], req_q.src_id[2:0], 11'h004};
        if (req_q.match_dest) res_next.mask_high = res_next.mask_high | MKH_D_F1;
        if (req_q.match_src) begin
          res_next.mask_high = res_next.mask_high | MKH_S_F1;
          res_next.mask_low  = res_next.mask_low | MKL_S_F1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < FILTER_SLOTS; i++) begin
        tbl[i] <= '0;
      end
      bus_format <= 1'b1;
      done       <= 1'b0;
      free_vld   <= 1'b0;
      idx        <= '0;
    end else begin
      done <= cmd.emit;
      if (cfg_wr_en) bus_format <= cfg_wr_data;
      if (cmd.load) begin
        idx      <= '0;
        free_vld <= 1'b0;
      end else if (cmd.step) begin
        idx <= idx + 1'b1;
        if (cur_free && !free_vld) begin
          free_vld <= 1'b1;
          free_idx <= idx;
        end
      end
      if (cmd.write_entry) tbl[wr_idx] <= req_q;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) req_q <= request;
    if (cmd.emit) result <= res_next;
  end

  `ASSERT_ALWAYS(a_refused_zero, clk, rst,
    !done || result.status == ST_ADDED ||
    (result.slot == '0 && result.id_high == '0 && result.mask_high == '0),
    "refused result carries nonzero fields")
  `ASSERT_ALWAYS(a_write_free_slot, clk, rst,
    !cmd.write_entry || (!tbl[wr_idx].match_dest && !tbl[wr_idx].match_src),
    "entry written over a used slot")
  `ASSERT_ALWAYS(a_added_has_flags, clk, rst,
    !done || result.status != ST_ADDED || result.mask_high != MKH_BASE,
    "added filter matches on nothing")

endmodule

@@ src/can_acceptance_filter_allocator_unit.sv @@
// Top level of the CAN acceptance filter allocator: controller plus datapath.
// Depends on cafa_pkg, cafa_ctrl and cafa_dp.
//
//  channel   ports                     handshake
//  --------  ------------------------  ---------------------------------
//  request   start, busy, request      transfer when start && !busy
//  result    done, result              one-cycle strobe, no stall
//  config    cfg_wr_en, cfg_wr_data    write when cfg_wr_en
//
// A request with no match flag returns its result the cycle after start.
// Otherwise busy stays high while the scan visits the slots in order: up to the
// last slot when no repeat is found, stopping early when a repeat is found;
// the result appears in the cycle after the last scan step, busy already low.
// Reset (rst, synchronous) frees all slots and sets bus_format to 1.
// The receiver cannot stall; each result is valid for exactly one cycle.
module can_acceptance_filter_allocator_unit #(
  parameter int FILTER_SLOTS = cafa_pkg::FILTER_SLOTS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  cafa_pkg::req_t request,
  input  logic           cfg_wr_en,
  input  logic           cfg_wr_data,
  output logic           done,
  output cafa_pkg::res_t result
);
  import cafa_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  cafa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  cafa_dp #(
    .FILTER_SLOTS (FILTER_SLOTS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .request     (request),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .stat        (stat),
    .done        (done),
    .result      (result)
  );

endmodule

@@ verif/can_acceptance_filter_allocator_unit_tb.sv @@
// Self-checking testbench for the CAN acceptance filter allocator top level.
// Depends on cafa_pkg and can_acceptance_filter_allocator_unit; keeps its own
// shadow copy of the filter table and bus format to predict every result.
module can_acceptance_filter_allocator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cafa_pkg::*;

  localparam int SLOTS      = FILTER_SLOTS_DEF;
  localparam int ITEMS_PER  = 600;
  localparam int STALL_LIMIT = 4000;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  req_t request;
  logic cfg_wr_en;
  logic cfg_wr_data;
  logic done;
  res_t result;

  can_acceptance_filter_allocator_unit #(.FILTER_SLOTS(SLOTS)) uut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .request    (request),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .done       (done),
    .result     (result)
  );

  typedef struct {
    bit      set_fmt;
    bit      fmt;
    req_t    req;
    bit      typed;
    status_t typed_status;
  } dir_row_t;

  req_t     shadow_filters [SLOTS];
  bit       shadow_format;
  res_t     pending_results[$];
  dir_row_t directed_rows[$];
  int       mismatches;
  int       quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Works out the allocator's answer and updates the shadow table.
  function automatic res_t predict_add(input req_t r);
    res_t o;
    int   free_idx;
    bit   dup;
    bit   same;
    o = '0;
    dup = 1'b0;
    free_idx = -1;
    if (!r.match_dest && !r.match_src) begin
      o.status = ST_NONE;
      return o;
    end
    for (int i = 0; i < SLOTS; i++) begin
      if (shadow_filters[i].match_dest == r.match_dest &&
          shadow_filters[i].match_src == r.match_src) begin
        same = 1'b1;
        if (r.match_dest && (shadow_filters[i].dest_type != r.dest_type ||
                             shadow_filters[i].dest_id != r.dest_id))
          same = 1'b0;
        if (r.match_src && (shadow_filters[i].source_type != r.source_type ||
                            shadow_filters[i].src_id != r.src_id))
          same = 1'b0;
        if (same) dup = 1'b1;
      end
    end
    if (dup) begin
      o.status = ST_REPEAT;
      return o;
    end
    for (int i = 0; i < SLOTS; i++) begin
      if (free_idx < 0 && !shadow_filters[i].match_dest && !shadow_filters[i].match_src)
        free_idx = i;
    end
    if (free_idx < 0) begin
      o.status = ST_FULL;
      return o;
    end
    shadow_filters[free_idx] = r;
    o.status = ST_ADDED;
    o.slot   = free_idx[SLOT_W-1:0];
    if (!shadow_format) begin
      o.id_high   = {3'b101, r.dest_type[3:0], r.dest_id, r.source_type[3:0], r.src_id[3]};
      o.id_low    = {r.src_id[2:0], 13'h0004};
      o.mask_high = 16'hE000 | (r.match_dest ? 16'hFFE0 : 16'h0)
                             | (r.match_src ? 16'h001F : 16'h0);
      o.mask_low  = 16'h0006 | (r.match_src ? 16'hE000 : 16'h0);
    end else begin
      o.id_high   = {3'b001, r.dest_type, r.dest_id[2:0], r.source_type[5:2]};
      o.id_low    = {r.source_type[1:0], r.src_id[2:0], 11'h004};
      o.mask_high = 16'hE000 | (r.match_dest ? 16'hFFF0 : 16'h0)
                             | (r.match_src ? 16'h000F : 16'h0);
      o.mask_low  = 16'h0006 | (r.match_src ? 16'hF800 : 16'h0);
    end
    return o;
  endfunction

  function automatic req_t make_req(input bit md, input bit ms, input int dt, input int di,
                                    input int st, input int si);
    req_t r;
    r.match_dest  = md;
    r.match_src   = ms;
    r.dest_type   = dt[5:0];
    r.dest_id     = di[3:0];
    r.source_type = st[5:0];
    r.src_id      = si[3:0];
    return r;
  endfunction

  function automatic void row(input bit set_fmt, input bit fmt, input req_t r,
                              input bit typed, input status_t s);
    dir_row_t d;
    d.set_fmt      = set_fmt;
    d.fmt          = fmt;
    d.req          = r;
    d.typed        = typed;
    d.typed_status = s;
    directed_rows.push_back(d);
  endfunction

  // Mostly repeats of stored filters with scrambled don't-care fields,
  // plus some with the match mode switched, empty requests and noise.
  function automatic req_t random_request();
    req_t r;
    int   pick;
    bit [1:0] flags;
    r = req_t'($bits(req_t)'($urandom));
    pick = $urandom_range(99);
    if (pick < 15) begin
      r.match_dest = 1'b0;
      r.match_src  = 1'b0;
    end else if (pick < 75) begin
      r = shadow_filters[$urandom_range(SLOTS - 1)];
      if (!r.match_dest) begin
        r.dest_type = 6'($urandom);
        r.dest_id   = 4'($urandom);
      end
      if (!r.match_src) begin
        r.source_type = 6'($urandom);
        r.src_id      = 4'($urandom);
      end
      if ($urandom_range(4) == 0) begin
        flags = {r.match_dest, r.match_src};
        while (flags == {r.match_dest, r.match_src} || flags == 2'b00)
          flags = 2'($urandom_range(3));
        {r.match_dest, r.match_src} = flags;
      end
    end
    return r;
  endfunction

  task automatic send_request(input req_t r, input bit typed, input status_t s);
    res_t want;
    start   <= 1'b1;
    request <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    want = predict_add(r);
    if (typed) begin
      want = '0;
      want.status = s;
    end
    pending_results.push_back(want);
  endtask

  task automatic sender_gap(input int pct);
    while ($urandom_range(99) < pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  // With nothing outstanding start is already low, so it is left alone.
  task automatic drain();
    if (pending_results.size() != 0) begin
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clk);
    end
  endtask

  task automatic write_format(input bit v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    shadow_format = v;
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : result_check
    res_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing outstanding, expected none, got 0x%0h",
                 $time, result);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", 16'(want.status), 16'(result.status));
        check_field("slot", 16'(want.slot), 16'(result.slot));
        check_field("id_high", want.id_high, result.id_high);
        check_field("id_low", want.id_low, result.id_low);
        check_field("mask_high", want.mask_high, result.mask_high);
        check_field("mask_low", want.mask_low, result.mask_low);
      end
    end
  end

  // Any transfer in either direction counts as progress.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done)
      quiet_cycles = 0;
    else
      quiet_cycles = quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int idle_pct [3];
    rst         <= 1'b1;
    start       <= 1'b0;
    request     <= '0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= 1'b0;
    mismatches   = 0;
    quiet_cycles = 0;
    shadow_format = 1'b1;
    for (int i = 0; i < SLOTS; i++) shadow_filters[i] = '0;
    idle_pct = '{7, 79, 0};

    // Six-bit type layout out of reset.
    row(0, 0, make_req(0, 0, 63, 15, 63, 15), 1, ST_NONE);
    row(0, 0, make_req(0, 0, 0, 0, 0, 0), 1, ST_NONE);
    row(0, 0, make_req(1, 0, 63, 15, 63, 15), 0, ST_ADDED);
    row(0, 0, make_req(0, 1, 0, 0, 63, 15), 0, ST_ADDED);
    row(0, 0, make_req(1, 1, 0, 0, 0, 0), 0, ST_ADDED);
    row(0, 0, make_req(1, 0, 63, 15, 0, 0), 1, ST_REPEAT);   // source fields ignored
    row(0, 0, make_req(1, 1, 63, 15, 63, 15), 0, ST_ADDED);  // same values, other mode
    row(0, 0, make_req(1, 0, 63, 14, 0, 0), 0, ST_ADDED);
    // Four-bit layout; entries stored before stay in place.
    row(1, 0, make_req(1, 0, 42, 5, 21, 10), 0, ST_ADDED);
    row(0, 0, make_req(0, 1, 0, 0, 63, 8), 0, ST_ADDED);
    row(0, 0, make_req(1, 1, 63, 15, 63, 15), 1, ST_REPEAT);
    row(0, 0, make_req(1, 1, 48, 0, 48, 0), 0, ST_ADDED);
    row(0, 0, make_req(0, 1, 0, 0, 12, 7), 0, ST_ADDED);
    row(0, 0, make_req(0, 0, 21, 10, 42, 5), 1, ST_NONE);
    row(1, 1, make_req(0, 1, 0, 0, 42, 15), 0, ST_ADDED);
    row(0, 0, make_req(1, 0, 1, 8, 0, 0), 0, ST_ADDED);
    row(0, 0, make_req(1, 1, 21, 10, 42, 5), 0, ST_ADDED);
    row(1, 0, make_req(1, 0, 15, 0, 0, 0), 0, ST_ADDED);
    row(0, 0, make_req(0, 1, 0, 0, 1, 1), 0, ST_ADDED);      // last free slot
    row(0, 0, make_req(1, 1, 7, 7, 7, 7), 1, ST_FULL);
    row(0, 0, make_req(0, 1, 9, 9, 1, 1), 1, ST_REPEAT);     // repeat wins over full
    row(0, 0, make_req(0, 0, 0, 0, 0, 0), 1, ST_NONE);
    row(1, 1, make_req(1, 0, 2, 0, 0, 0), 1, ST_FULL);

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].set_fmt) begin
        drain();
        write_format(directed_rows[i].fmt);
      end
      send_request(directed_rows[i].req, directed_rows[i].typed,
                   directed_rows[i].typed_status);
    end

    for (int ph = 0; ph < 3; ph++) begin
      drain();
      write_format(ph == 0 ? 1'b0 : ph == 1 ? 1'b1 : 1'($urandom_range(1)));
      for (int n = 0; n < ITEMS_PER; n++) begin
        if ($urandom_range(59) == 0) drain();
        sender_gap(idle_pct[ph]);
        send_request(random_request(), 1'b0, ST_ADDED);
      end
    end

    drain();
    repeat (SLOTS + 4) @(posedge clk);
    if (mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
